// File: rtl/rgbpal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbpal_pkg;

    localparam int PIX_W   = 16;
    localparam int COLOR_W = 15;
    localparam int INDEX_W = 9;

    localparam logic [2:0] MODE_ADAPT255 = 3'd0;
    localparam logic [2:0] MODE_ADAPT223 = 3'd1;
    localparam logic [2:0] MODE_FIX15    = 3'd2;
    localparam logic [2:0] MODE_GRAY32   = 3'd3;
    localparam logic [2:0] MODE_GRAY15   = 3'd4;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    localparam logic [4:0] CLS_LO  = 5'd11;
    localparam logic [4:0] CLS_HI  = 5'd20;
    localparam logic [4:0] CLS_MID = 5'd15;

    localparam logic [4:0] CHAN_MIN = 5'd6;
    localparam logic [4:0] CHAN_MAX = 5'd30;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic               nw;
        logic [7:0]         slot;
        logic [COLOR_W-1:0] color;
        logic               ovf;
    } t_result;

    // round up to a multiple of 4, then clamp
    function automatic logic [4:0] chan_reduce(input logic [4:0] c);
        logic [5:0] t;
        t = (c[1:0] != 2'b00) ? ({1'b0, c[4:2], 2'b00} + 6'd4) : {1'b0, c};
        if (t < {1'b0, CHAN_MIN}) t = {1'b0, CHAN_MIN};
        if (t > {1'b0, CHAN_MAX}) t = {1'b0, CHAN_MAX};
        return t[4:0];
    endfunction

    function automatic logic [3:0] classify15(input logic [4:0] r,
                                              input logic [4:0] g,
                                              input logic [4:0] b);
        if (r <= CLS_LO && g < CLS_LO && b < CLS_LO) return 4'd1;
        if (r >= CLS_HI && g >= CLS_HI && b >= CLS_HI) return 4'd2;
        if (r >= CLS_HI && g >= CLS_HI) return (b >= CLS_MID) ? 4'd2 : 4'd7;
        if (r >= CLS_HI && b >= CLS_HI) return (g >= CLS_MID) ? 4'd2 : 4'd8;
        if (g >= CLS_HI && b >= CLS_HI) return (r >= CLS_MID) ? 4'd2 : 4'd9;
        if (r >= CLS_HI) begin
            if (g > CLS_LO && b > CLS_LO) return (g < b) ? 4'd8 : 4'd7;
            if (g > CLS_LO) return 4'd10;
            if (b > CLS_LO) return 4'd13;
            return 4'd4;
        end
        if (g >= CLS_HI) begin
            if (r > CLS_LO && b > CLS_LO) return (r < b) ? 4'd9 : 4'd7;
            if (r > CLS_LO) return 4'd11;
            if (b > CLS_LO) return 4'd14;
            return 4'd5;
        end
        if (b >= CLS_HI) begin
            if (r > CLS_LO && g > CLS_LO) return (r < g) ? 4'd9 : 4'd8;
            if (g > CLS_LO) return 4'd12;
            if (r > CLS_LO) return 4'd15;
            return 4'd6;
        end
        return 4'd3;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rgbpal_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbpal_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [2:0]  o_mode,
    output logic      [7:0]  o_offset
);
    import rgbpal_pkg::*;

    logic [2:0] r_mode;
    logic [7:0] r_offset;
    logic       w_wr;
    logic       w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_sel  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ADAPT255;
            r_offset <= 8'd0;
        end else if (w_wr) begin
            unique case (w_sel)
                REG_MODE:   r_mode   <= pwdata[2:0];
                REG_OFFSET: r_offset <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            REG_MODE:   prdata = {29'd0, r_mode};
            REG_OFFSET: prdata = {24'd0, r_offset};
        endcase
    end

    assign o_mode   = r_mode;
    assign o_offset = r_offset;

endmodule

`default_nettype wire

// File: rtl/rgbpal_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// one write port, one registered read port
// a write lands at the end of an item, before the next item issues its first
// read, so no forwarding path is needed
module rgbpal_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [AW-1:0]                  i_waddr,
    input  wire logic [rgbpal_pkg::COLOR_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                  i_raddr,
    output logic      [rgbpal_pkg::COLOR_W-1:0] o_rdata
);
    import rgbpal_pkg::*;

    logic [COLOR_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/rgbpal_map.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbpal_map (
    input  wire logic [rgbpal_pkg::PIX_W-1:0]   i_pixel,
    input  wire logic [2:0]                     i_mode,
    input  wire logic [7:0]                     i_offset,
    output logic      [rgbpal_pkg::INDEX_W-1:0] o_index
);
    import rgbpal_pkg::*;

    logic [4:0]  w_r, w_g, w_b;
    logic [6:0]  w_sum;
    logic [13:0] w_prod;
    logic [4:0]  w_avg;
    logic [7:0]  w_base;

    assign w_r    = i_pixel[4:0];
    assign w_g    = i_pixel[9:5];
    assign w_b    = i_pixel[14:10];
    assign w_sum  = {2'b00, w_r} + {2'b00, w_g} + {2'b00, w_b};
    // divide by 3 via reciprocal, exact for every reachable sum (at most 93)
    assign w_prod = {7'd0, w_sum} * 14'd171;
    assign w_avg  = w_prod[13:9];

    always_comb begin
        w_base = 8'd0;
        if (!i_pixel[15]) begin
            unique case (i_mode)
                MODE_FIX15:  w_base = {4'd0, classify15(w_r, w_g, w_b)};
                MODE_GRAY32: w_base = {3'd0, w_avg} + 8'd1;
                MODE_GRAY15: w_base = (w_avg[4:1] == 4'd0) ? 8'd1 : {4'd0, w_avg[4:1]};
                default:     w_base = 8'd0;
            endcase
        end
    end

    assign o_index = {1'b0, w_base} + {1'b0, i_offset};

endmodule

`default_nettype wire

// File: rtl/rgb555_palette_color_reducer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | valid        | stall        | payload
// ---------+--------------+--------------+------------------------------------------
// in       | i_in_valid   | o_in_stall   | i_pixel, i_first_of_image
// out      | o_out_valid  | i_out_stall  | o_pixel_index, o_new_entry, o_entry_slot,
//          |              |              | o_entry_color, o_overflow
// config   | psel/penable | pready       | paddr, pwdata, prdata
//
// Fixed, gray and transparent beats skip the search; one beat is handled at a time.
// Adaptive beats: slots 1..used compared up to a hit, else (or if empty) a miss;
// used = entries in play (up to 254); one compare per cycle.
// Reset clears the fill count and control; the palette memory is not cleared.
// A finished result sits in the output register while the next beat is taken;
// a full output register holds the following result until the stall drops.
module rgb555_palette_color_reducer #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_pixel,
    input  wire logic        i_first_of_image,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [8:0]  o_pixel_index,
    output logic             o_new_entry,
    output logic      [7:0]  o_entry_slot,
    output logic      [14:0] o_entry_color,
    output logic             o_overflow
);
    import rgbpal_pkg::*;

    localparam int AW    = $clog2(PALETTE_DEPTH);
    localparam int LIM_A = (255 > PALETTE_DEPTH - 1) ? PALETTE_DEPTH - 1 : 255;
    localparam int LIM_B = (223 > PALETTE_DEPTH - 1) ? PALETTE_DEPTH - 1 : 223;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_MISS   = 2'd2;
    localparam logic [1:0] S_FIN    = 2'd3;

    logic [2:0]         w_mode;
    logic [7:0]         w_offset;
    logic [INDEX_W-1:0] w_map_idx;

    logic [1:0]         r_state;
    logic [7:0]         r_fill;
    logic               r_cv;
    logic               r_out_valid;
    logic [COLOR_W-1:0] r_pd;
    logic [7:0]         r_used;
    logic [7:0]         r_t;
    logic [7:0]         r_ct;
    t_result            r_res;
    t_result            r_out;

    logic               w_accept;
    logic [7:0]         w_fill_eff;
    logic [7:0]         w_limit;
    logic [7:0]         w_lim_m1;
    logic [7:0]         w_used;
    logic               w_adapt;
    logic [COLOR_W-1:0] w_pd;
    logic [COLOR_W-1:0] w_rdata;
    logic               w_hit;
    logic               w_alloc;
    logic [7:0]         w_slot;
    logic               w_load;

    rgbpal_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_mode   (w_mode),
        .o_offset (w_offset)
    );

    rgbpal_map u_map (
        .i_pixel  (i_pixel),
        .i_mode   (w_mode),
        .i_offset (w_offset),
        .o_index  (w_map_idx)
    );

    rgbpal_ram #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_alloc),
        .i_waddr (w_slot[AW-1:0]),
        .i_wdata (r_pd),
        .i_raddr (r_t[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_fill_eff = i_first_of_image ? 8'd0 : r_fill;
    assign w_limit    = (w_mode == MODE_ADAPT255) ? LIM_A[7:0] : LIM_B[7:0];
    assign w_lim_m1   = w_limit - 8'd1;
    assign w_used     = (w_fill_eff > w_lim_m1) ? w_lim_m1 : w_fill_eff;
    assign w_adapt    = !i_pixel[15]
                        && (w_mode == MODE_ADAPT255 || w_mode == MODE_ADAPT223);
    assign w_pd       = {chan_reduce(i_pixel[14:10]), chan_reduce(i_pixel[9:5]),
                         chan_reduce(i_pixel[4:0])};
    assign w_hit      = r_cv && (w_rdata == r_pd);
    assign w_alloc    = (r_state == S_MISS) && (r_used < w_lim_m1);
    assign w_slot     = r_used + 8'd1;
    assign w_load     = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 8'd0;
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_first_of_image) begin
                            r_fill <= 8'd0;
                        end
                        r_pd   <= w_pd;
                        r_used <= w_used;
                        r_t    <= 8'd1;
                        r_cv   <= 1'b0;
                        if (w_adapt) begin
                            r_state <= (w_used == 8'd0) ? S_MISS : S_SEARCH;
                        end else begin
                            r_res   <= '{w_map_idx, 1'b0, 8'd0, {COLOR_W{1'b0}}, 1'b0};
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SEARCH: begin
                    r_ct <= r_t;
                    r_t  <= r_t + 8'd1;
                    if (w_hit) begin
                        r_res   <= '{{1'b0, r_ct} + {1'b0, w_offset}, 1'b0, 8'd0,
                                     {COLOR_W{1'b0}}, 1'b0};
                        r_cv    <= 1'b0;
                        r_state <= S_FIN;
                    end else if (r_cv && r_ct == r_used) begin
                        r_cv    <= 1'b0;
                        r_state <= S_MISS;
                    end else begin
                        r_cv <= (r_t <= r_used);
                    end
                end
                S_MISS: begin
                    if (w_alloc) begin
                        r_fill <= w_slot;
                        r_res  <= '{{1'b0, w_slot} + {1'b0, w_offset}, 1'b1, w_slot,
                                    r_pd, 1'b0};
                    end else begin
                        r_res <= '{{1'b0, w_limit}, 1'b0, 8'd0, {COLOR_W{1'b0}}, 1'b1};
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_out.idx;
    assign o_new_entry   = r_out.nw;
    assign o_entry_slot  = r_out.slot;
    assign o_entry_color = r_out.color;
    assign o_overflow    = r_out.ovf;

    a_nw_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_new_entry && o_overflow))
        else $error("new entry and overflow both set");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= PALETTE_DEPTH - 1)
        else $error("fill count beyond palette");

    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv |-> (r_ct != 8'd0 && r_ct <= r_used && r_state == S_SEARCH))
        else $error("compare outside used slots");

    a_alloc_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alloc |=> (r_fill == r_res.slot && r_res.nw))
        else $error("fill count does not track new slot");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rgbpal_pkg::*;

    localparam int PAL_DEPTH   = 256;
    localparam int HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 300;

    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    typedef enum {FILL_SWEEP, KEEP_GOING, SCENE, RAW_MIX} t_style;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  mode;
        logic [7:0]  offset;
        logic [15:0] pix;
        logic        first;
        bit          known;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_pixel = '0;
    logic        i_first_of_image = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [8:0]  o_pixel_index;
    logic        o_new_entry;
    logic [7:0]  o_entry_slot;
    logic [14:0] o_entry_color;
    logic        o_overflow;

    // predictor state
    logic [14:0] pal_copy [PAL_DEPTH];
    int          fill_level = 0;
    logic [2:0]  cur_mode = MODE_ADAPT255;
    logic [7:0]  cur_offset = '0;

    t_result pending_lookups [$];
    t_row    plan [$];
    bit      idle_on = 1'b0;
    bit      hold_req = 1'b0;
    int      errors = 0;
    int      n_beats = 0;
    int      n_new = 0;
    int      n_full = 0;
    int      n_settings = 0;

    always #10 i_clk = ~i_clk;

    rgb555_palette_color_reducer #(.PALETTE_DEPTH(PAL_DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_pixel(i_pixel), .i_first_of_image(i_first_of_image),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_pixel_index(o_pixel_index), .o_new_entry(o_new_entry),
        .o_entry_slot(o_entry_slot), .o_entry_color(o_entry_color),
        .o_overflow(o_overflow)
    );

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("MISMATCH @%0t %s: got %0d want %0d", $time, what, got, want);
    endtask

    // round channel up to a multiple of 4, keep it within 6..30
    function automatic logic [4:0] squeeze_chan(input logic [4:0] c);
        logic [5:0] up;
        up = (c[1:0] == 2'b00) ? {1'b0, c} : ({1'b0, c} | 6'd3) + 6'd1;
        if (up < 6'd6) up = 6'd6;
        if (up > 6'd30) up = 6'd30;
        return up[4:0];
    endfunction

    function automatic int color_class(input int r, input int g, input int b);
        int lo, hi, mid;
        lo = 11;
        hi = 20;
        mid = (lo + hi) / 2;
        if (r <= lo && g < lo && b < lo) return 1;
        if (r >= hi && g >= hi && b >= hi) return 2;
        if (r >= hi && g >= hi) return (b >= mid) ? 2 : 7;
        if (r >= hi && b >= hi) return (g >= mid) ? 2 : 8;
        if (g >= hi && b >= hi) return (r >= mid) ? 2 : 9;
        if (r >= hi) begin
            if (g > lo && b > lo) return (g < b) ? 8 : 7;
            if (g > lo) return 10;
            if (b > lo) return 13;
            return 4;
        end
        if (g >= hi) begin
            if (r > lo && b > lo) return (r < b) ? 9 : 7;
            if (r > lo) return 11;
            if (b > lo) return 14;
            return 5;
        end
        if (b >= hi) begin
            if (r > lo && g > lo) return (r < g) ? 9 : 8;
            if (g > lo) return 12;
            if (r > lo) return 15;
            return 6;
        end
        return 3;
    endfunction

    function automatic t_result reduced_index(input logic [15:0] pix, input logic first);
        t_result     res;
        logic [14:0] col;
        int          r, g, b, total, lim, used, hit, lvl, k;
        res = '0;
        r = int'(pix[4:0]);
        g = int'(pix[9:5]);
        b = int'(pix[14:10]);
        total = r + g + b;
        if (first) fill_level = 0;
        res.idx = {1'b0, cur_offset};
        if (pix[15]) return res;
        case (cur_mode)
            MODE_ADAPT255, MODE_ADAPT223: begin
                lim = (cur_mode == MODE_ADAPT255) ? 255 : 223;
                if (lim > PAL_DEPTH - 1) lim = PAL_DEPTH - 1;
                col = {squeeze_chan(pix[14:10]), squeeze_chan(pix[9:5]),
                       squeeze_chan(pix[4:0])};
                used = (fill_level > lim - 1) ? lim - 1 : fill_level;
                hit = 0;
                for (k = 1; k <= used && hit == 0; k++)
                    if (pal_copy[k] == col) hit = k;
                if (hit != 0) begin
                    res.idx = 9'(hit + int'(cur_offset));
                end else if (used < lim - 1) begin
                    pal_copy[used + 1] = col;
                    fill_level = used + 1;
                    res.idx = 9'(fill_level + int'(cur_offset));
                    res.nw = 1'b1;
                    res.slot = 8'(fill_level);
                    res.color = col;
                end else begin
                    res.idx = 9'(lim);
                    res.ovf = 1'b1;
                end
            end
            MODE_FIX15: res.idx = 9'(color_class(r, g, b) + int'(cur_offset));
            MODE_GRAY32: res.idx = 9'(1 + total / 3 + int'(cur_offset));
            MODE_GRAY15: begin
                lvl = (total / 3) & 'h1e;
                res.idx = 9'(((lvl == 0) ? 1 : lvl / 2) + int'(cur_offset));
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [4:0] sweep_level(input int k);
        if (k == 0) return 5'd6;
        if (k == 7) return 5'd30;
        return 5'(4 * k + 4);
    endfunction

    function automatic logic [4:0] raw_for(input logic [4:0] level);
        logic [4:0] c;
        do c = 5'($urandom_range(0, 31)); while (squeeze_chan(c) != level);
        return c;
    endfunction

    function automatic void add_cfg(input logic [2:0] mode, input logic [7:0] offset);
        t_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.mode = mode;
        row.offset = offset;
        plan.push_back(row);
    endfunction

    function automatic void add_beat(input logic [15:0] pix, input logic first,
                                     input bit known, input t_result want);
        t_row row;
        row = '{default: '0};
        row.pix = pix;
        row.first = first;
        row.known = known;
        row.want = want;
        plan.push_back(row);
    endfunction

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== val) report_mismatch("register readback", int'(prdata), int'(val));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [2:0] mode, input logic [7:0] offset);
        drain();
        write_reg({REG_MODE, 2'b00}, {29'd0, mode});
        cur_mode = mode;
        write_reg({REG_OFFSET, 2'b00}, {24'd0, offset});
        cur_offset = offset;
        n_settings++;
    endtask

    task automatic send_pixel(input logic [15:0] pix, input logic first,
                              input bit known, input t_result given);
        t_result res;
        int      gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel <= pix;
        i_first_of_image <= first;
        do @(posedge i_clk); while (o_in_stall);
        res = reduced_index(pix, first);
        pending_lookups.push_back(known ? given : res);
        n_beats++;
    endtask

    task automatic run_phase(input logic [2:0] mode, input logic [7:0] offset, input int n,
                             input t_style how, input bit busy, input bit hold);
        logic [15:0] pix;
        logic [15:0] scene [32];
        logic        first;
        int          k0, k, i;
        set_config(mode, offset);
        idle_on = busy;
        if (hold) hold_req = 1'b1;
        k0 = $urandom_range(0, 511);
        for (i = 0; i < 32; i++) scene[i] = 16'($urandom_range(0, 'h7fff));
        for (i = 0; i < n; i++) begin
            first = 1'b0;
            case (how)
                FILL_SWEEP: begin
                    k = (k0 + i) % 512;
                    pix = {1'b0, raw_for(sweep_level(k / 64)),
                           raw_for(sweep_level((k / 8) % 8)), raw_for(sweep_level(k % 8))};
                    first = (i == 0);
                end
                KEEP_GOING: pix = {1'b0, 15'($urandom)};
                SCENE: begin
                    pix = scene[$urandom_range(0, 31)];
                    if ($urandom_range(0, 9) == 0) pix[15] = 1'b1;
                    first = (i == 0) || ($urandom_range(0, 29) == 0);
                end
                default: begin
                    pix = 16'($urandom);
                    first = ($urandom_range(0, 15) == 0);
                end
            endcase
            send_pixel(pix, first, 1'b0, '0);
        end
    endtask

    // output stall: random bursts, or one long hold-off on request
    initial begin : out_stall_gen
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                n = $urandom_range(1, 15);
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : result_check
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
                if (pending_lookups.size() == 0) begin
                    report_mismatch("result beat with nothing pending",
                                    int'(o_pixel_index), -1);
                end else begin
                    want = pending_lookups.pop_front();
                    if (want.nw) n_new++;
                    if (want.ovf) n_full++;
                    if (o_pixel_index !== want.idx)
                        report_mismatch("pixel_index", int'(o_pixel_index), int'(want.idx));
                    if (o_new_entry !== want.nw)
                        report_mismatch("new_entry", int'(o_new_entry), int'(want.nw));
                    if (o_entry_slot !== want.slot)
                        report_mismatch("entry_slot", int'(o_entry_slot), int'(want.slot));
                    if (o_entry_color !== want.color)
                        report_mismatch("entry_color", int'(o_entry_color), int'(want.color));
                    if (o_overflow !== want.ovf)
                        report_mismatch("overflow", int'(o_overflow), int'(want.ovf));
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall) ||
                (psel && penable && pready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        t_row row;
        // right after reset: registers at their reset values
        add_beat(16'h0000, 1'b1, 1'b1, '{9'd1, 1'b1, 8'd1, 15'h18c6, 1'b0});
        add_beat(16'h8000, 1'b0, 1'b1, '{9'd0, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_beat(16'h7fff, 1'b0, 1'b1, '{9'd2, 1'b1, 8'd2, 15'h7bde, 1'b0});
        add_beat(16'h0000, 1'b0, 1'b1, '{9'd1, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_beat(16'h0421, 1'b0, 1'b1, '{9'd1, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_cfg(MODE_ADAPT255, 8'd240);
        add_beat(16'h7fff, 1'b0, 1'b1, '{9'd242, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_beat(16'hffff, 1'b0, 1'b1, '{9'd240, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_beat(16'h1234, 1'b1, 1'b0, '0);
        add_cfg(MODE_FIX15, 8'd16);
        add_beat(16'h0000, 1'b0, 1'b1, '{9'd17, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_beat(16'h7fff, 1'b0, 1'b1, '{9'd18, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_beat(16'h5180, 1'b0, 1'b0, '0);   // blue with green
        add_beat(16'h500c, 1'b0, 1'b0, '0);   // blue with red
        add_beat(16'h5000, 1'b0, 1'b0, '0);   // blue alone
        add_cfg(MODE_GRAY32, 8'd0);
        add_beat(16'h7fff, 1'b0, 1'b1, '{9'd32, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_beat(16'h0000, 1'b0, 1'b1, '{9'd1, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_cfg(MODE_GRAY15, 8'd32);
        add_beat(16'h7fff, 1'b0, 1'b1, '{9'd47, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_beat(16'h0000, 1'b0, 1'b1, '{9'd33, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_cfg(MODE_SPARE5, 8'd48);
        add_beat(16'h1234, 1'b0, 1'b1, '{9'd48, 1'b0, 8'd0, 15'h0000, 1'b0});
        add_cfg(MODE_ADAPT223, 8'd0);
        add_beat(16'h0000, 1'b0, 1'b0, '0);
        add_beat(16'h0000, 1'b1, 1'b0, '0);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;
        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_cfg) set_config(row.mode, row.offset);
            else send_pixel(row.pix, row.first, row.known, row.want);
        end

        run_phase(MODE_ADAPT255, 8'd0, 260, FILL_SWEEP, 1'b1, 1'b0);
        run_phase(MODE_ADAPT223, 8'd112, 40, KEEP_GOING, 1'b1, 1'b0);
        run_phase(MODE_ADAPT223, 8'd16, 228, FILL_SWEEP, 1'b0, 1'b0);
        run_phase(MODE_ADAPT255, 8'd240, 30, KEEP_GOING, 1'b1, 1'b0);
        run_phase(MODE_FIX15, 8'd240, 60, RAW_MIX, 1'b0, 1'b1);
        run_phase(MODE_GRAY32, 8'd0, 40, RAW_MIX, 1'b1, 1'b0);
        run_phase(MODE_GRAY15, 8'd128, 40, RAW_MIX, 1'b1, 1'b0);
        run_phase(MODE_ADAPT255, 8'd64, 60, SCENE, 1'b1, 1'b0);
        run_phase(MODE_ADAPT223, 8'd32, 60, SCENE, 1'b1, 1'b0);
        run_phase(MODE_SPARE7, 8'd240, 12, RAW_MIX, 1'b1, 1'b0);
        run_phase(MODE_FIX15, 8'd0, 30, RAW_MIX, 1'b0, 1'b0);
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_lookups.size() != 0)
            report_mismatch("results never delivered", 0, pending_lookups.size());

        $display("covered %0d pixel beats across %0d register settings",
                 n_beats, n_settings);
        $display("%0d palette allocations and %0d full-palette results checked",
                 n_new, n_full);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
